[rtl/impq_pkg.sv]
// Package for the indexed min-priority queue.
// Holds default sizes and action codes; used by the top level.
package impq_pkg;

    localparam int ENTRIES_DEF   = 1024;
    localparam int TAG_BITS_DEF  = 8;
    localparam int COST_BITS_DEF = 32;

    typedef enum logic [1:0] {
        ACT_UPDATE  = 2'd0,
        ACT_EXCLUDE = 2'd1,
        ACT_POP     = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

endpackage

[rtl/impq_ram.sv]
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module impq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/indexed_min_priority_queue_top.sv]
// Indexed min-priority queue: one RAM holds {live, tag, cost} per entry.
// Depends on impq_pkg and impq_ram.
//
// Usage: one input word (action, entry_index, tag, cost_key) per handshake on
// in_valid/in_ready; one result word (found, out_index, out_tag, out_cost,
// occupancy) per input on out_valid/out_ready.
// Update and exclude take one read-modify-write.
// Pop scans the RAM one entry per cycle through its single read port.
// Clear sweeps the RAM one entry per cycle.
// One word is in flight at a time; the result sits in an output register, so
// the next word is accepted while an earlier result waits to be taken. A
// stalled receiver blocks the finish of the following word only.
// After reset the block sweeps the RAM with in_ready low.
module indexed_min_priority_queue_top
    import impq_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int TAG_BITS  = TAG_BITS_DEF,
    parameter int COST_BITS = COST_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         action,
    input  logic [$clog2(ENTRIES)-1:0]         entry_index,
    input  logic [TAG_BITS-1:0]                tag,
    input  logic [COST_BITS-1:0]               cost_key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [$clog2(ENTRIES)-1:0]         out_index,
    output logic [TAG_BITS-1:0]                out_tag,
    output logic [COST_BITS-1:0]               out_cost,
    output logic [$clog2(ENTRIES+1)-1:0]       occupancy
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int DW    = 1 + TAG_BITS + COST_BITS;
    localparam logic [IDX_W:0] ENT_N = (IDX_W+1)'(ENTRIES);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOOK = 5'b00010,
        S_SCAN = 5'b00100,
        S_CLR  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic                 boot_reg, boot_next;
    logic [1:0]           act_reg, act_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [COST_BITS-1:0] cost_reg, cost_next;
    logic [IDX_W:0]       cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     ridx_reg, ridx_next;
    logic                 have_reg, have_next;
    logic [IDX_W-1:0]     bidx_reg, bidx_next;
    logic [TAG_BITS-1:0]  btag_reg, btag_next;
    logic [COST_BITS-1:0] bcost_reg, bcost_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic                 rfound_reg, rfound_next;
    logic [IDX_W-1:0]     ridxo_reg, ridxo_next;
    logic [TAG_BITS-1:0]  rtag_reg, rtag_next;
    logic [COST_BITS-1:0] rcost_reg, rcost_next;
    logic                 ov_reg, ov_next;
    logic                 of_reg, of_next;
    logic [IDX_W-1:0]     oi_reg, oi_next;
    logic [TAG_BITS-1:0]  ot_reg, ot_next;
    logic [COST_BITS-1:0] oc_reg, oc_next;
    logic [CNT_W-1:0]     oo_reg, oo_next;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [DW-1:0]    wdata, rdata;
    logic             r_live;
    logic [TAG_BITS-1:0]  r_tag;
    logic [COST_BITS-1:0] r_cost;

    impq_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign r_live = rdata[DW-1];
    assign r_tag  = rdata[COST_BITS +: TAG_BITS];
    assign r_cost = rdata[COST_BITS-1:0];

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign found     = of_reg;
    assign out_index = oi_reg;
    assign out_tag   = ot_reg;
    assign out_cost  = oc_reg;
    assign occupancy = oo_reg;

    always_comb
    begin
        state_next  = state_reg;
        boot_next   = boot_reg;
        act_next    = act_reg;
        idx_next    = idx_reg;
        tag_next    = tag_reg;
        cost_next   = cost_reg;
        cnt_next    = cnt_reg;
        pend_next   = pend_reg;
        ridx_next   = ridx_reg;
        have_next   = have_reg;
        bidx_next   = bidx_reg;
        btag_next   = btag_reg;
        bcost_next  = bcost_reg;
        live_next   = live_reg;
        rfound_next = rfound_reg;
        ridxo_next  = ridxo_reg;
        rtag_next   = rtag_reg;
        rcost_next  = rcost_reg;
        ov_next     = ov_reg;
        of_next     = of_reg;
        oi_next     = oi_reg;
        ot_next     = ot_reg;
        oc_next     = oc_reg;
        oo_next     = oo_reg;
        we          = 1'b0;
        waddr       = idx_reg;
        wdata       = {1'b1, tag_reg, cost_reg};
        raddr       = idx_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                raddr = entry_index;
                if (in_valid)
                begin
                    act_next    = action;
                    idx_next    = entry_index;
                    tag_next    = tag;
                    cost_next   = cost_key;
                    rfound_next = 1'b0;
                    ridxo_next  = '0;
                    rtag_next   = '0;
                    rcost_next  = '1;
                    cnt_next    = '0;
                    pend_next   = 1'b0;
                    have_next   = 1'b0;
                    case (action_t'(action))
                        ACT_UPDATE, ACT_EXCLUDE:
                        begin
                            if ({1'b0, entry_index} < ENT_N)
                            begin
                                state_next = S_LOOK;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        ACT_POP:   state_next = S_SCAN;
                        ACT_CLEAR: state_next = S_CLR;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_LOOK:
            begin
                if (act_reg == ACT_UPDATE)
                begin
                    if (!r_live)
                    begin
                        we        = 1'b1;
                        live_next = live_reg + 1'b1;
                    end
                    else if (cost_reg < r_cost)
                    begin
                        we = 1'b1;
                    end
                end
                else if (r_live)
                begin
                    we        = 1'b1;
                    wdata     = {1'b0, r_tag, r_cost};
                    live_next = live_reg - 1'b1;
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                raddr = cnt_reg[IDX_W-1:0];
                if (pend_reg && r_live && (!have_reg || r_cost < bcost_reg))
                begin
                    have_next  = 1'b1;
                    bidx_next  = ridx_reg;
                    btag_next  = r_tag;
                    bcost_next = r_cost;
                end
                if (cnt_reg < ENT_N)
                begin
                    pend_next = 1'b1;
                    ridx_next = cnt_reg[IDX_W-1:0];
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (have_reg)
                        begin
                            we          = 1'b1;
                            waddr       = bidx_reg;
                            wdata       = {1'b0, btag_reg, bcost_reg};
                            live_next   = live_reg - 1'b1;
                            rfound_next = 1'b1;
                            ridxo_next  = bidx_reg;
                            rtag_next   = btag_reg;
                            rcost_next  = bcost_reg;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = cnt_reg[IDX_W-1:0];
                wdata    = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ENT_N - 1'b1)
                begin
                    live_next = '0;
                    boot_next = 1'b0;
                    if (boot_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    of_next    = rfound_reg;
                    oi_next    = ridxo_reg;
                    ot_next    = rtag_reg;
                    oc_next    = rcost_reg;
                    oo_next    = live_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            boot_reg  <= 1'b1;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            have_reg  <= 1'b0;
            live_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            boot_reg  <= boot_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            have_reg  <= have_next;
            live_reg  <= live_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        idx_reg    <= idx_next;
        tag_reg    <= tag_next;
        cost_reg   <= cost_next;
        ridx_reg   <= ridx_next;
        bidx_reg   <= bidx_next;
        btag_reg   <= btag_next;
        bcost_reg  <= bcost_next;
        rfound_reg <= rfound_next;
        ridxo_reg  <= ridxo_next;
        rtag_reg   <= rtag_next;
        rcost_reg  <= rcost_next;
        of_reg     <= of_next;
        oi_reg     <= oi_next;
        ot_reg     <= ot_next;
        oc_reg     <= oc_next;
        oo_reg     <= oo_next;
    end

endmodule

[tb/tb_top.sv]
// Testbench for indexed_min_priority_queue_top: directed table, then random words.
// Results are checked against typed table rows, else a priority queue predictor.
// Depends on impq_pkg and the RTL of the top level.
module tb_top;
    import impq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          N_ENT      = 1024;
    localparam int          N_RANDOM   = 630;
    localparam int          HOLD_LEN   = 300;
    localparam longint      CYCLE_MAX  = 4000000;
    localparam logic [31:0] COST_NONE  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        found;
        logic [9:0]  idx;
        logic [7:0]  tag;
        logic [31:0] cost;
        logic [10:0] occ;
    } result_t;

    typedef struct {
        action_t     act;
        logic [9:0]  idx;
        logic [7:0]  tag;
        logic [31:0] cost;
        bit          typed;
        result_t     res;
    } row_t;

    logic        clk, rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    logic [1:0]  action;
    logic [9:0]  entry_index, out_index;
    logic [7:0]  tag, out_tag;
    logic [31:0] cost_key, out_cost;
    logic        found;
    logic [10:0] occupancy;

    bit          q_live [N_ENT];
    logic [31:0] q_cost [N_ENT];
    logic [7:0]  q_tag  [N_ENT];
    int          q_count;

    result_t     pending_results[$];
    int          errors;
    longint      cycles;
    int          idle_mode;
    bit          hold_req;

    indexed_min_priority_queue_top dut (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    function automatic result_t queue_step(action_t a, logic [9:0] i, logic [7:0] t,
                                           logic [31:0] c);
        result_t r;
        int      best;
        r = '{found: 0, idx: 0, tag: 0, cost: COST_NONE, occ: 0};
        best = -1;
        case (a)
            ACT_UPDATE:
            begin
                if (!q_live[i])
                begin
                    q_live[i] = 1;
                    q_cost[i] = c;
                    q_tag[i]  = t;
                    q_count++;
                end
                else if (c < q_cost[i])
                begin
                    q_cost[i] = c;
                    q_tag[i]  = t;
                end
            end
            ACT_EXCLUDE:
            begin
                if (q_live[i])
                begin
                    q_live[i] = 0;
                    q_count--;
                end
            end
            ACT_POP:
            begin
                for (int k = 0; k < N_ENT; k++)
                    if (q_live[k] && (best < 0 || q_cost[k] < q_cost[best]))
                        best = k;
                if (best >= 0)
                begin
                    r.found = 1;
                    r.idx   = best[9:0];
                    r.tag   = q_tag[best];
                    r.cost  = q_cost[best];
                    q_live[best] = 0;
                    q_count--;
                end
            end
            default:
            begin
                for (int k = 0; k < N_ENT; k++)
                    q_live[k] = 0;
                q_count = 0;
            end
        endcase
        r.occ = q_count[10:0];
        return r;
    endfunction

    // drive one word at the falling edge, hold until accepted
    task automatic send_word(action_t a, logic [9:0] i, logic [7:0] t, logic [31:0] c,
                             bit typed, result_t tr);
        result_t r;
        int      gap_pct;
        gap_pct = (idle_mode == 0) ? 11 : (idle_mode == 1) ? 81 : 0;
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid    <= 1;
        action      <= a;
        entry_index <= i;
        tag         <= t;
        cost_key    <= c;
        do
            @(posedge clk);
        while (!in_ready);
        r = queue_step(a, i, t, c);
        pending_results = {pending_results, (typed ? tr : r)};
    endtask

    task automatic drop_valid();
        @(negedge clk);
        in_valid <= 0;
    endtask

    function automatic result_t res(bit f, int i, int t, logic [31:0] c, int o);
        return '{found: f, idx: i[9:0], tag: t[7:0], cost: c, occ: o[10:0]};
    endfunction

    initial
    begin
        row_t        rows[$];
        action_t     a;
        logic [9:0]  i;
        logic [31:0] c;
        int          pick;

        rst_n = 0; in_valid = 0; out_ready = 0;
        action = 0; entry_index = 0; tag = 0; cost_key = 0;
        errors = 0; idle_mode = 0; hold_req = 0; q_count = 0;
        foreach (q_live[k]) q_live[k] = 0;
        repeat (3) @(negedge clk);
        rst_n = 1;

        rows = '{
            '{ACT_POP,     0,    0,    0,            1, res(0, 0, 0, COST_NONE, 0)},
            '{ACT_UPDATE,  0,    0,    0,            1, res(0, 0, 0, COST_NONE, 1)},
            '{ACT_UPDATE,  1023, 255,  COST_NONE,    1, res(0, 0, 0, COST_NONE, 2)},
            '{ACT_UPDATE,  0,    7,    5,            1, res(0, 0, 0, COST_NONE, 2)},
            '{ACT_UPDATE,  1023, 8'hAA, 32'hFFFFFFFE, 1, res(0, 0, 0, COST_NONE, 2)},
            '{ACT_UPDATE,  500,  8'h55, 0,           1, res(0, 0, 0, COST_NONE, 3)},
            '{ACT_POP,     0,    0,    0,            1, res(1, 0, 0, 0, 2)},
            '{ACT_POP,     0,    0,    0,            1, res(1, 500, 8'h55, 0, 1)},
            '{ACT_EXCLUDE, 7,    0,    0,            1, res(0, 0, 0, COST_NONE, 1)},
            '{ACT_EXCLUDE, 1023, 0,    0,            1, res(0, 0, 0, COST_NONE, 0)},
            '{ACT_UPDATE,  3,    1,    100,          0, res(0, 0, 0, 0, 0)},
            '{ACT_UPDATE,  4,    2,    100,          0, res(0, 0, 0, 0, 0)},
            '{ACT_UPDATE,  5,    3,    32'h8000_0000, 0, res(0, 0, 0, 0, 0)},
            '{ACT_POP,     0,    0,    0,            0, res(0, 0, 0, 0, 0)},
            '{ACT_UPDATE,  4,    9,    50,           0, res(0, 0, 0, 0, 0)},
            '{ACT_UPDATE,  4,    10,   50,           0, res(0, 0, 0, 0, 0)},
            '{ACT_POP,     0,    0,    0,            0, res(0, 0, 0, 0, 0)},
            '{ACT_CLEAR,   0,    0,    0,            1, res(0, 0, 0, COST_NONE, 0)},
            '{ACT_POP,     0,    0,    0,            1, res(0, 0, 0, COST_NONE, 0)},
            '{ACT_UPDATE,  10,   8'hFF, 7,           0, res(0, 0, 0, 0, 0)},
            '{ACT_CLEAR,   0,    0,    0,            1, res(0, 0, 0, COST_NONE, 0)}
        };
        foreach (rows[r])
            send_word(rows[r].act, rows[r].idx, rows[r].tag, rows[r].cost,
                      rows[r].typed, rows[r].res);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            idle_mode = (n < N_RANDOM / 3) ? 0 : (n < 2 * N_RANDOM / 3) ? 1 : 2;
            if (n == 150)
            begin
                drop_valid();
                wait (pending_results.size() == 0);
            end
            if (n == 500)
                hold_req = 1;
            pick = $urandom_range(99);
            a = (pick < 50) ? ACT_UPDATE : (pick < 66) ? ACT_EXCLUDE :
                (pick < 98) ? ACT_POP : ACT_CLEAR;
            i = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(31));
            case ($urandom_range(4))
                0: c = $urandom;
                1: c = $urandom_range(1) ? 32'h0 : COST_NONE;
                default: c = $urandom_range(15);
            endcase
            send_word(a, i, 8'($urandom), c, 0, '0);
        end
        drop_valid();
        wait (pending_results.size() == 0);
        repeat (1100) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int hold_cnt;
        int stall_pct;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            stall_pct = (idle_mode == 0) ? 81 : (idle_mode == 1) ? 11 : 0;
            if (hold_req && hold_cnt < HOLD_LEN)
            begin
                hold_cnt++;
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want, got;
        cycles++;
        if (cycles > CYCLE_MAX)
        begin
            $display("%0t timeout", $time);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = '{found, out_index, out_tag, out_cost, occupancy};
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected word: got %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.found !== want.found)
                    $display("%0t found: exp %0d got %0d", $time, want.found, got.found);
                if (got.idx !== want.idx)
                    $display("%0t out_index: exp %0d got %0d", $time, want.idx, got.idx);
                if (got.tag !== want.tag)
                    $display("%0t out_tag: exp %h got %h", $time, want.tag, got.tag);
                if (got.cost !== want.cost)
                    $display("%0t out_cost: exp %h got %h", $time, want.cost, got.cost);
                if (got.occ !== want.occ)
                    $display("%0t occupancy: exp %0d got %0d", $time, want.occ, got.occ);
                if (got !== want)
                    errors++;
            end
        end
    end

    initial cycles = 0;
endmodule
